// File: src/trsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsd_pkg
// Shared types and constants for the subblock Rice decompressor.
// ----------------------------------------------------------------------------
package trsd_pkg;

  localparam int ROW_BYTES          = 16;
  localparam int SUBBLOCK_ROWS_DEF  = 4;
  localparam int MAX_ROWS           = 8;
  // wide enough for a byte count of the largest subblock
  localparam int COUNT_W            = $clog2(ROW_BYTES * MAX_ROWS + 1);

  localparam int  PADDR_W           = 3;
  localparam logic REG_PLANE_KIND   = 1'b0;   // word index of plane_kind

  localparam logic PLANE_LUMA       = 1'b0;
  localparam logic PLANE_CHROMA     = 1'b1;

  localparam int ESC_BASE           = 7;      // escape after ESC_BASE + k ones
  localparam logic [3:0] K_SOLID    = 4'd8;

  typedef struct packed {
    logic               chroma;
    logic [COUNT_W-1:0] count;
  } job_t;

endpackage

// File: src/tiled_subblock_rice_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_subblock_rice_decompressor
// Rice/predictive subblock decoder: byte intake, job queue, decoder.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// input    in         start & !busy          byte_value, last_byte
// result   out        pixel_strobe (1 cycle) pixel_value, pixel_index, last_pixel
// config   in         psel&penable&pwrite    paddr, pwdata (plane_kind)
//
// One byte is taken per cycle while busy is low. The last byte starts a
// decode; busy stays high until the final word has been issued.
// Decode is bit serial, one bit per cycle while a fetched byte is at hand;
// each pixel reads its up, up-right and up-left neighbours, then is written.
// The 64 words then stream out one per cycle; a full subblock streams out directly.
// Synchronous active-high reset clears the FSM, intake count, queue and
// plane_kind; buffer and pixel store need no clearing. Results cannot stall.
// ----------------------------------------------------------------------------
module tiled_subblock_rice_decompressor
  import trsd_pkg::*;
#(
  parameter int SUBBLOCK_ROWS = SUBBLOCK_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         byte_value,
  input  logic               last_byte,
  output logic               pixel_strobe,
  output logic [7:0]         pixel_value,
  output logic [5:0]         pixel_index,
  output logic               last_pixel,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(ROW_BYTES * SUBBLOCK_ROWS);

  logic          plane_kind;
  logic          accept;
  logic          push;
  job_t          push_job;
  job_t          head;
  logic          q_empty;
  logic          pop;
  logic          active;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PLANE_KIND) ? {31'd0, plane_kind} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_kind <= PLANE_LUMA;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PLANE_KIND)) begin
      plane_kind <= pwdata[0];
    end
  end

  assign busy   = !q_empty || active;
  assign accept = start && !busy;

  trsd_front #(.SUBBLOCK_ROWS(SUBBLOCK_ROWS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .plane_kind (plane_kind),
    .push       (push),
    .push_job   (push_job),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  trsd_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  trsd_back #(.SUBBLOCK_ROWS(SUBBLOCK_ROWS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (!q_empty),
    .job          (head),
    .job_pop      (pop),
    .active       (active),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .pixel_strobe (pixel_strobe),
    .pixel_value  (pixel_value),
    .pixel_index  (pixel_index),
    .last_pixel   (last_pixel)
  );

endmodule

// File: src/trsd_jobq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsd_jobq
// Two-entry queue of decode jobs between intake and decoder.
// ----------------------------------------------------------------------------
module trsd_jobq
  import trsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t       entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign empty   = (fill == 2'd0);
  assign do_push = push && (fill != 2'd2);
  assign do_pop  = pop && !empty;
  assign head    = entry[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: src/trsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsd_front
// Byte intake: buffers compressed bytes and posts a job on the last one.
// ----------------------------------------------------------------------------
module trsd_front
  import trsd_pkg::*;
#(
  parameter int SUBBLOCK_ROWS = SUBBLOCK_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  input  logic       plane_kind,
  output logic       push,
  output job_t       push_job,
  input  logic                                    rd_en,
  input  logic [$clog2(ROW_BYTES*SUBBLOCK_ROWS)-1:0] rd_addr,
  output logic [7:0] rd_data
);

  localparam int SB_BYTES = ROW_BYTES * SUBBLOCK_ROWS;
  localparam int AW       = $clog2(SB_BYTES);
  localparam int CW       = $clog2(SB_BYTES + 1);

  logic [7:0]    mem [SB_BYTES];
  logic [CW-1:0] count;
  logic          room;
  logic [CW-1:0] count_next;

  assign room       = (count < CW'(SB_BYTES));
  assign count_next = room ? count + CW'(1) : count;

  assign push            = accept && last_byte;
  assign push_job.chroma = plane_kind;
  assign push_job.count  = COUNT_W'(count_next);

  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[count[AW-1:0]] <= byte_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= last_byte ? '0 : count_next;
    end
  end

endmodule

// File: src/trsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsd_back
// Decoder: bit-serial Rice decode with gradient/edge prediction, then
// streams the 64 words out of the pixel store, or the buffer if full.
// ----------------------------------------------------------------------------
module trsd_back
  import trsd_pkg::*;
#(
  parameter int SUBBLOCK_ROWS = SUBBLOCK_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       active,
  output logic                                    rd_en,
  output logic [$clog2(ROW_BYTES*SUBBLOCK_ROWS)-1:0] rd_addr,
  input  logic [7:0] rd_data,
  output logic       pixel_strobe,
  output logic [7:0] pixel_value,
  output logic [5:0] pixel_index,
  output logic       last_pixel
);

  localparam int SB_BYTES = ROW_BYTES * SUBBLOCK_ROWS;
  localparam int HALF     = SB_BYTES / 2;
  localparam int AW       = $clog2(SB_BYTES);
  localparam int CW       = $clog2(SB_BYTES + 1);
  localparam int BPW      = CW + 3;
  localparam int YW       = $clog2(SUBBLOCK_ROWS);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_HDR   = 12'b000000000010,
    S_FILL  = 12'b000000000100,
    S_PA    = 12'b000000001000,
    S_PB    = 12'b000000010000,
    S_PC    = 12'b000000100000,
    S_PD    = 12'b000001000000,
    S_UNARY = 12'b000010000000,
    S_SUF   = 12'b000100000000,
    S_EXTRA = 12'b001000000000,
    S_WR    = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t        state;
  logic [CW-1:0] rc;
  logic          chroma;
  logic          pass;
  logic          plane;
  logic [BPW-1:0] bitp;
  logic          have_byte;
  logic          fetch_pend;
  logic          zero_byte;
  logic [3:0]    cnt;
  logic [3:0]    nbits;
  logic [10:0]   acc;
  logic [3:0]    rice_k;
  logic [3:0]    ones;
  logic [3:0]    x;
  logic [YW-1:0] y;
  logic [7:0]    up_r, ur_r, rt_r, pred_r;
  logic [AW-1:0] fi;
  logic [AW-1:0] oi;
  logic          out_pass;
  logic [AW-1:0] out_idx;
  logic          out_last;

  logic [7:0]    store [SB_BYTES];
  logic [7:0]    st_q;
  logic          st_we, st_re;
  logic [AW-1:0] st_wa, st_ra;
  logic [7:0]    st_wd;

  // bit reader
  logic [CW-1:0] n;
  logic [CW-1:0] phys;
  logic          bit_end;
  logic          bit_ok;
  logic          bit_b;
  logic          want_bit;
  logic          take;
  logic          fetch;

  assign n       = bitp[BPW-1:3];
  assign phys    = {n[CW-1:4], ~n[3:0]};   // rows run right to left
  assign bit_end = (n >= rc);
  assign bit_ok  = bit_end || have_byte;
  assign bit_b   = (bit_end || zero_byte) ? 1'b0 : rd_data[~bitp[2:0]];
  assign want_bit = (state == S_HDR) || (state == S_EXTRA)
                 || ((state == S_UNARY) && (ones != 4'(ESC_BASE) + rice_k))
                 || ((state == S_SUF) && (cnt != nbits));
  assign take    = want_bit && bit_ok;
  assign fetch   = want_bit && !bit_end && !have_byte && !fetch_pend;

  assign rd_en   = fetch || ((state == S_OUT) && pass);
  assign rd_addr = (state == S_OUT) ? oi : phys[AW-1:0];

  // plane geometry
  logic [3:0]    wl;
  logic [AW-1:0] base;
  logic [AW-1:0] plane_last;
  assign wl         = chroma ? 4'd7 : 4'd15;
  assign base       = plane ? AW'(HALF) : '0;
  assign plane_last = chroma ? AW'(HALF - 1) : AW'(SB_BYTES - 1);

  function automatic logic [AW-1:0] pos(input logic [AW-1:0] b, input logic c,
                                        input logic [YW-1:0] yy,
                                        input logic [3:0] xx);
    logic [AW-1:0] rowoff;
    rowoff = c ? (AW'(yy) << 3) : (AW'(yy) << 4);
    return b + rowoff + AW'(xx);
  endfunction

  logic [YW-1:0] ym1;
  assign ym1 = y - YW'(1);

  // prediction from up, up-right, up-left (st_q) and right neighbour
  logic [7:0] ul, hi, lo, guess;
  always_comb begin
    ul = st_q;
    hi = (up_r > rt_r) ? up_r : rt_r;
    lo = (up_r < rt_r) ? up_r : rt_r;
    if (y == '0) begin
      guess = rt_r;
    end else if (x == wl) begin
      guess = up_r;
    end else if (ur_r <= hi && ur_r >= lo) begin
      guess = rt_r + up_r - ur_r;
    end else if (x == 4'd0) begin
      guess = (ur_r > hi) ? hi : lo;
    end else if (ul <= hi && ul >= lo) begin
      guess = up_r - ul + rt_r;
    end else begin
      guess = (ul >= hi) ? hi : lo;
    end
  end

  logic [10:0] hdr_next;
  logic [3:0]  k_new;
  logic [11:0] v;
  logic [7:0]  mag;
  logic [7:0]  pix;
  assign hdr_next = {acc[9:0], bit_b};
  assign k_new    = {1'b0, hdr_next[10:8]} + 4'd1;
  assign v        = 12'(acc) + (12'(ones) << rice_k[2:0]);
  assign mag      = v[8:1];
  assign pix      = v[0] ? pred_r - mag : pred_r + mag;

  logic [AW-1:0] omap;
  assign omap = (!chroma) ? oi : (oi[0] ? (oi >> 1) : AW'(HALF) + (oi >> 1));

  always_comb begin
    st_we = 1'b0;
    st_wa = '0;
    st_wd = rt_r;
    st_re = 1'b0;
    st_ra = '0;
    case (state)
      S_HDR: begin
        st_we = take && (cnt == 4'd10);
        st_wa = pos(base, chroma, '0, wl);
        st_wd = hdr_next[7:0];
      end
      S_FILL: begin
        st_we = 1'b1;
        st_wa = base + fi;
      end
      S_PA: begin
        st_re = 1'b1;
        st_ra = pos(base, chroma, ym1, x);
      end
      S_PB: begin
        st_re = 1'b1;
        st_ra = pos(base, chroma, ym1, x + 4'd1);
      end
      S_PC: begin
        st_re = 1'b1;
        st_ra = pos(base, chroma, ym1, x - 4'd1);
      end
      S_WR: begin
        st_we = 1'b1;
        st_wa = pos(base, chroma, y, x);
        st_wd = pix;
      end
      S_OUT: begin
        st_re = !pass;
        st_ra = omap;
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_wa] <= st_wd;
    end
    if (st_re) begin
      st_q <= store[st_ra];
    end
  end

  assign job_pop = (state == S_IDLE) && job_valid;
  assign active  = (state != S_IDLE);

  logic plane_end;   // set where the current plane has been fully written
  assign plane_end = ((state == S_FILL) && (fi == plane_last))
                  || ((state == S_WR) && (x == 4'd0) && (y == YW'(SUBBLOCK_ROWS - 1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      have_byte    <= 1'b0;
      fetch_pend   <= 1'b0;
      bitp         <= '0;
      rice_k       <= '0;
      pixel_strobe <= 1'b0;
    end else begin
      pixel_strobe <= 1'b0;

      if (want_bit) begin
        if (!bit_end && have_byte) begin
          bitp <= bitp + BPW'(1);
          if (bitp[2:0] == 3'd7) begin
            have_byte <= 1'b0;
          end
        end else if (fetch) begin
          fetch_pend <= 1'b1;
          zero_byte  <= (phys >= rc);
        end else if (fetch_pend) begin
          fetch_pend <= 1'b0;
          have_byte  <= 1'b1;
        end
      end

      if (plane_end) begin
        if (chroma && !plane) begin
          plane <= 1'b1;
          cnt   <= '0;
          acc   <= '0;
          state <= S_HDR;
        end else begin
          oi    <= '0;
          state <= S_OUT;
        end
      end else begin
        case (state)
          S_IDLE: begin
            if (job_valid) begin
              rc         <= CW'(job.count);
              chroma     <= job.chroma;
              pass       <= (CW'(job.count) == CW'(SB_BYTES));
              plane      <= 1'b0;
              bitp       <= '0;
              have_byte  <= 1'b0;
              fetch_pend <= 1'b0;
              cnt        <= '0;
              acc        <= '0;
              oi         <= '0;
              state      <= (CW'(job.count) == CW'(SB_BYTES)) ? S_OUT : S_HDR;
            end
          end
          S_HDR: begin
            if (take) begin
              acc <= hdr_next;
              cnt <= cnt + 4'd1;
              if (cnt == 4'd10) begin
                rice_k <= k_new;
                rt_r   <= hdr_next[7:0];
                fi     <= '0;
                x      <= wl - 4'd1;
                y      <= '0;
                state  <= (k_new == K_SOLID) ? S_FILL : S_PA;
              end
            end
          end
          S_FILL: begin
            fi <= fi + AW'(1);
          end
          S_PA: state <= S_PB;
          S_PB: begin
            up_r  <= st_q;
            state <= S_PC;
          end
          S_PC: begin
            ur_r  <= st_q;
            state <= S_PD;
          end
          S_PD: begin
            pred_r <= guess;
            ones   <= '0;
            state  <= S_UNARY;
          end
          S_UNARY: begin
            if (ones == 4'(ESC_BASE) + rice_k) begin
              nbits <= (rice_k >= 4'd4) ? 4'd7 : 4'd8;
              cnt   <= '0;
              acc   <= '0;
              state <= S_SUF;
            end else if (take) begin
              if (bit_b) begin
                ones <= ones + 4'd1;
              end else begin
                nbits <= (ones != 4'd0) ? rice_k : rice_k - 4'd1;
                cnt   <= '0;
                acc   <= '0;
                state <= S_SUF;
              end
            end
          end
          S_SUF: begin
            if (cnt == nbits) begin
              // a non-zero short value carries one more bit
              state <= ((ones == 4'd0) && (acc != '0)) ? S_EXTRA : S_WR;
            end else if (take) begin
              acc <= hdr_next;
              cnt <= cnt + 4'd1;
            end
          end
          S_EXTRA: begin
            if (take) begin
              acc   <= hdr_next;
              state <= S_WR;
            end
          end
          S_WR: begin
            rt_r <= pix;
            if (x == 4'd0) begin
              y <= y + YW'(1);
              x <= wl;
            end else begin
              x <= x - 4'd1;
            end
            state <= S_PA;
          end
          S_OUT: begin
            pixel_strobe <= 1'b1;
            out_pass     <= pass;
            out_idx      <= oi;
            out_last     <= (oi == AW'(SB_BYTES - 1));
            oi           <= oi + AW'(1);
            if (oi == AW'(SB_BYTES - 1)) begin
              state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  assign pixel_value = out_pass ? rd_data : st_q;
  assign pixel_index = 6'(out_idx);
  assign last_pixel  = out_last;

endmodule

// File: src/trsd_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsd_check
// Port-level checks on the result burst of the decompressor.
// ----------------------------------------------------------------------------
module trsd_check (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       pixel_strobe,
  input logic [5:0] pixel_index,
  input logic       last_pixel
);

  // a burst runs without gaps up to its last word
  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    pixel_strobe && !last_pixel |=> pixel_strobe)
    else $error("result burst broken before last word");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    pixel_strobe && !last_pixel |=> pixel_index == 6'($past(pixel_index) + 6'd1))
    else $error("result index did not step by one");

  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_strobe) |-> pixel_index == 6'd0)
    else $error("result burst did not start at index zero");

  a_busy_in_burst: assert property (@(posedge clk) disable iff (rst)
    pixel_strobe && !last_pixel |-> busy)
    else $error("input offered while results still pending");

endmodule

bind tiled_subblock_rice_decompressor trsd_check u_trsd_check (.*);
